>>> rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

>>> rtl/core/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

	localparam int DEFAULT_MAX_BLOCKS = 64;

	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 27;
	localparam int HDR_W      = 7;
	localparam int CNT_FLD_W  = 7;
	localparam int MD_FLD_W   = 13;
	localparam int MUL_STEPS  = 32;

	localparam logic [SIZE_W-1:0] SIZE_CAP        = 27'd100000000;
	localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST  = 32'd1048576;
	localparam logic [HDR_W-1:0]  HEADER_RST      = 7'd32;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_REALLOC = 2'd2,
		OP_CALLOC  = 2'd3
	} opcode_t;

	typedef enum logic {
		CFG_HEAP_LIMIT   = 1'b0,
		CFG_HEADER_BYTES = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MUL,
		S_SCAN,
		S_APPEND,
		S_COMMIT,
		S_RELEASE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ADDR_W-1:0] request_size;
		logic [ADDR_W-1:0] element_count;
		logic [ADDR_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]    result_address;
		logic                 success;
		logic [SIZE_W-1:0]    zero_fill_bytes;
		logic [ADDR_W-1:0]    move_source;
		logic [SIZE_W-1:0]    move_bytes;
		logic [CNT_FLD_W-1:0] free_blocks;
		logic [ADDR_W-1:0]    free_bytes;
		logic [CNT_FLD_W-1:0] total_blocks;
		logic [ADDR_W-1:0]    total_bytes;
		logic [MD_FLD_W-1:0]  metadata_bytes;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
		logic              free;
	} blk_entry_t;

	typedef struct packed {
		logic              done;
		logic              ovf;
		logic [SIZE_W-1:0] prod;
	} mul_res_t;

endpackage

`default_nettype wire

>>> rtl/core/ffba_table.sv
`default_nettype none

module ffba_table #(
	parameter int DEPTH = ffba_pkg::DEFAULT_MAX_BLOCKS,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [IDX_W-1:0]       waddr,
	input  wire ffba_pkg::blk_entry_t   wdata,
	input  wire logic                   re,
	input  wire logic [IDX_W-1:0]       raddr,
	output ffba_pkg::blk_entry_t        rdata
);

	ffba_pkg::blk_entry_t mem [DEPTH];
	ffba_pkg::blk_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/ffba_mul.sv
`default_nettype none

module ffba_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ffba_pkg::SIZE_W-1:0]   multiplicand,
	input  wire logic [ffba_pkg::ADDR_W-1:0]   multiplier,
	output ffba_pkg::mul_res_t                 res
);

	localparam int STEP_W = $clog2(ffba_pkg::MUL_STEPS);
	localparam int SUM_W  = ffba_pkg::SIZE_W + 2;

	logic                          busy_q;
	logic                          done_q;
	logic                          ovf_q;
	logic [STEP_W-1:0]             step_q;
	logic [ffba_pkg::SIZE_W-1:0]   a_q;
	logic [ffba_pkg::ADDR_W-1:0]   b_q;
	logic [ffba_pkg::SIZE_W-1:0]   acc_q;
	logic [SUM_W-1:0]              sum;

	// horner step, msb of the multiplier first
	always_comb begin
		sum = {1'b0, acc_q, 1'b0};
		if (b_q[ffba_pkg::ADDR_W-1]) begin
			sum = sum + SUM_W'(a_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == STEP_W'(ffba_pkg::MUL_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= multiplicand;
			b_q    <= multiplier;
			acc_q  <= '0;
			ovf_q  <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			b_q    <= {b_q[ffba_pkg::ADDR_W-2:0], 1'b0};
			acc_q  <= sum[ffba_pkg::SIZE_W-1:0];
			step_q <= step_q + 1'b1;
			if (sum > SUM_W'(ffba_pkg::SIZE_CAP)) begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign res.done = done_q;
	assign res.ovf  = ovf_q;
	assign res.prod = acc_q;

endmodule

`default_nettype wire

>>> rtl/core/first_fit_block_allocator.sv
// First-fit heap allocator over a table of up to MAX_BLOCKS blocks held in one
// single-port-write, registered-read memory. One request is worked at a time:
// req_stall stays high from acceptance until the result is loaded into the
// output register, which may still wait on rsp_stall while the next request is
// taken. Every table search (first fit or address lookup) reads one entry per
// cycle, so a request takes longer as block_count grows; an allocation that
// appends adds S_APPEND and S_COMMIT, a zeroed allocate waits for the
// bit-serial count times size product, and a reallocate that moves runs the
// lookup and the first-fit search back to back. Configuration writes through
// cfg_we/cfg_index/cfg_data are expected only while no request is in flight.
`default_nettype none

`include "assert_macros.svh"

module first_fit_block_allocator #(
	parameter int MAX_BLOCKS = ffba_pkg::DEFAULT_MAX_BLOCKS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [ffba_pkg::ADDR_W-1:0]  cfg_data,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire ffba_pkg::req_t               req_data,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output ffba_pkg::rsp_t                    rsp_data
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int AW    = ffba_pkg::ADDR_W;
	localparam int SW    = ffba_pkg::SIZE_W;
	localparam int MD_W  = ffba_pkg::HDR_W + CNT_W;

	ffba_pkg::state_t state_q, state_d;

	logic [1:0]              op_q, op_d;
	logic [AW-1:0]           rsize_q, rsize_d;
	logic [AW-1:0]           ecount_q, ecount_d;
	logic [AW-1:0]           baddr_q, baddr_d;
	logic [SW-1:0]           size_q, size_d;
	logic                    find_q, find_d;
	logic [CNT_W-1:0]        idx_q, idx_d;
	logic                    pend_s1, pend_d;
	logic [IDX_W-1:0]        pidx_s1;
	logic                    move_q, move_d;
	logic [IDX_W-1:0]        old_idx_q, old_idx_d;
	logic [SW-1:0]           old_size_q, old_size_d;
	logic                    old_free_q, old_free_d;
	logic [AW-1:0]           res_q, res_d;
	logic                    ok_q, ok_d;
	logic [AW-1:0]           msrc_q, msrc_d;
	logic [SW-1:0]           mbytes_q, mbytes_d;
	logic [AW:0]             end_q, end_d;
	logic [AW-1:0]           base_q, base_d;

	logic [CNT_W-1:0]        count_q, count_d;
	logic [CNT_W-1:0]        free_cnt_q, free_cnt_d;
	logic [AW-1:0]           heap_top_q, heap_top_d;
	logic [AW-1:0]           free_bytes_q, free_bytes_d;
	logic [AW-1:0]           used_q, used_d;

	logic [AW-1:0]           limit_q;
	logic [ffba_pkg::HDR_W-1:0] hdr_q;

	logic                    rsp_valid_q, rsp_valid_d;
	ffba_pkg::rsp_t          rsp_q, rsp_d;

	logic                    mem_we;
	logic [IDX_W-1:0]        mem_waddr;
	ffba_pkg::blk_entry_t    mem_wdata;
	logic                    mem_re;
	ffba_pkg::blk_entry_t    mem_rdata;

	logic                    mul_start;
	ffba_pkg::mul_res_t      mul_res;

	logic                    req_ok;
	logic                    size_bad;
	logic                    hit;
	logic [MD_W-1:0]         md_full;

	ffba_table #(
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	ffba_mul u_mul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplicand (rsize_q[SW-1:0]),
		.multiplier   (ecount_q),
		.res          (mul_res)
	);

	assign req_stall = (state_q != ffba_pkg::S_IDLE);
	assign req_ok    = req_valid && !req_stall;
	assign size_bad  = (rsize_q == '0) || (rsize_q > AW'(ffba_pkg::SIZE_CAP));
	assign md_full   = MD_W'(hdr_q) * MD_W'(count_q);

	always_comb begin
		if (find_q) begin
			hit = pend_s1 && (mem_rdata.start == baddr_q);
		end else begin
			hit = pend_s1 && mem_rdata.free && (size_q <= mem_rdata.size);
		end
	end

	always_comb begin
		state_d      = state_q;
		op_d         = op_q;
		rsize_d      = rsize_q;
		ecount_d     = ecount_q;
		baddr_d      = baddr_q;
		size_d       = size_q;
		find_d       = find_q;
		idx_d        = idx_q;
		pend_d       = 1'b0;
		move_d       = move_q;
		old_idx_d    = old_idx_q;
		old_size_d   = old_size_q;
		old_free_d   = old_free_q;
		res_d        = res_q;
		ok_d         = ok_q;
		msrc_d       = msrc_q;
		mbytes_d     = mbytes_q;
		end_d        = end_q;
		base_d       = base_q;
		count_d      = count_q;
		free_cnt_d   = free_cnt_q;
		heap_top_d   = heap_top_q;
		free_bytes_d = free_bytes_q;
		used_d       = used_q;
		rsp_valid_d  = rsp_valid_q && rsp_stall;
		rsp_d        = rsp_q;
		mem_we       = 1'b0;
		mem_waddr    = '0;
		mem_wdata    = '0;
		mem_re       = 1'b0;
		mul_start    = 1'b0;

		unique case (state_q)
			ffba_pkg::S_IDLE: begin
				if (req_ok) begin
					op_d     = req_data.opcode;
					rsize_d  = req_data.request_size;
					ecount_d = req_data.element_count;
					baddr_d  = req_data.block_address;
					res_d    = '0;
					ok_d     = 1'b0;
					msrc_d   = '0;
					mbytes_d = '0;
					move_d   = 1'b0;
					state_d  = ffba_pkg::S_DECODE;
				end
			end
			ffba_pkg::S_DECODE: begin
				idx_d  = '0;
				size_d = rsize_q[SW-1:0];
				unique case (op_q)
					ffba_pkg::OP_ALLOC: begin
						find_d  = 1'b0;
						state_d = size_bad ? ffba_pkg::S_DONE : ffba_pkg::S_SCAN;
					end
					ffba_pkg::OP_FREE: begin
						find_d = 1'b1;
						if (baddr_q == '0) begin
							ok_d    = 1'b1;
							state_d = ffba_pkg::S_DONE;
						end else begin
							state_d = ffba_pkg::S_SCAN;
						end
					end
					ffba_pkg::OP_REALLOC: begin
						find_d  = (baddr_q != '0);
						state_d = size_bad ? ffba_pkg::S_DONE : ffba_pkg::S_SCAN;
					end
					ffba_pkg::OP_CALLOC: begin
						find_d = 1'b0;
						if (size_bad || ecount_q == '0) begin
							state_d = ffba_pkg::S_DONE;
						end else begin
							mul_start = 1'b1;
							state_d   = ffba_pkg::S_MUL;
						end
					end
					default: begin
						state_d = ffba_pkg::S_DONE;
					end
				endcase
			end
			ffba_pkg::S_MUL: begin
				if (mul_res.done) begin
					size_d  = mul_res.prod;
					idx_d   = '0;
					state_d = mul_res.ovf ? ffba_pkg::S_DONE : ffba_pkg::S_SCAN;
				end
			end
			ffba_pkg::S_SCAN: begin
				if (hit) begin
					if (!find_q) begin
						// reuse a free block whole
						mem_we          = 1'b1;
						mem_waddr       = pidx_s1;
						mem_wdata       = mem_rdata;
						mem_wdata.free  = 1'b0;
						free_cnt_d      = free_cnt_q - 1'b1;
						free_bytes_d    = free_bytes_q - AW'(mem_rdata.size);
						res_d           = mem_rdata.start;
						ok_d            = 1'b1;
						state_d         = move_q ? ffba_pkg::S_RELEASE : ffba_pkg::S_DONE;
					end else if (op_q == ffba_pkg::OP_FREE) begin
						if (!mem_rdata.free) begin
							mem_we         = 1'b1;
							mem_waddr      = pidx_s1;
							mem_wdata      = mem_rdata;
							mem_wdata.free = 1'b1;
							free_cnt_d     = free_cnt_q + 1'b1;
							free_bytes_d   = free_bytes_q + AW'(mem_rdata.size);
						end
						ok_d    = 1'b1;
						state_d = ffba_pkg::S_DONE;
					end else if (rsize_q <= AW'(mem_rdata.size)) begin
						res_d   = baddr_q;
						ok_d    = 1'b1;
						state_d = ffba_pkg::S_DONE;
					end else begin
						// too small: remember it and search for a new block
						old_idx_d  = pidx_s1;
						old_size_d = mem_rdata.size;
						old_free_d = mem_rdata.free;
						move_d     = 1'b1;
						find_d     = 1'b0;
						idx_d      = '0;
					end
				end else if (idx_q < count_q) begin
					mem_re = 1'b1;
					idx_d  = idx_q + 1'b1;
					pend_d = 1'b1;
				end else begin
					state_d = find_q ? ffba_pkg::S_DONE : ffba_pkg::S_APPEND;
				end
			end
			ffba_pkg::S_APPEND: begin
				end_d  = {1'b0, heap_top_q} + (AW + 1)'(hdr_q) + (AW + 1)'(size_q);
				base_d = heap_top_q + AW'(hdr_q);
				if (count_q >= CNT_W'(MAX_BLOCKS)) begin
					state_d = ffba_pkg::S_DONE;
				end else begin
					state_d = ffba_pkg::S_COMMIT;
				end
			end
			ffba_pkg::S_COMMIT: begin
				if (end_q > {1'b0, limit_q}) begin
					state_d = ffba_pkg::S_DONE;
				end else begin
					mem_we          = 1'b1;
					mem_waddr       = count_q[IDX_W-1:0];
					mem_wdata.start = base_q;
					mem_wdata.size  = size_q;
					mem_wdata.free  = 1'b0;
					count_d         = count_q + 1'b1;
					heap_top_d      = end_q[AW-1:0];
					used_d          = used_q + AW'(size_q);
					res_d           = base_q;
					ok_d            = 1'b1;
					state_d         = move_q ? ffba_pkg::S_RELEASE : ffba_pkg::S_DONE;
				end
			end
			ffba_pkg::S_RELEASE: begin
				if (!old_free_q) begin
					mem_we          = 1'b1;
					mem_waddr       = old_idx_q;
					mem_wdata.start = baddr_q;
					mem_wdata.size  = old_size_q;
					mem_wdata.free  = 1'b1;
					free_cnt_d      = free_cnt_q + 1'b1;
					free_bytes_d    = free_bytes_q + AW'(old_size_q);
				end
				msrc_d   = baddr_q;
				mbytes_d = old_size_q;
				state_d  = ffba_pkg::S_DONE;
			end
			ffba_pkg::S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_valid_d            = 1'b1;
					rsp_d.result_address   = ok_q ? res_q : '0;
					rsp_d.success          = ok_q;
					rsp_d.zero_fill_bytes  = (ok_q && op_q == ffba_pkg::OP_CALLOC) ? size_q : '0;
					rsp_d.move_source      = msrc_q;
					rsp_d.move_bytes       = mbytes_q;
					rsp_d.free_blocks      = ffba_pkg::CNT_FLD_W'(free_cnt_q);
					rsp_d.free_bytes       = free_bytes_q;
					rsp_d.total_blocks     = ffba_pkg::CNT_FLD_W'(count_q);
					rsp_d.total_bytes      = used_q;
					rsp_d.metadata_bytes   = ffba_pkg::MD_FLD_W'(md_full);
					state_d                = ffba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffba_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1      <= 1'b0;
			rsp_valid_q  <= 1'b0;
			count_q      <= '0;
			free_cnt_q   <= '0;
			heap_top_q   <= '0;
			free_bytes_q <= '0;
			used_q       <= '0;
			limit_q      <= ffba_pkg::HEAP_LIMIT_RST;
			hdr_q        <= ffba_pkg::HEADER_RST;
		end else begin
			pend_s1      <= pend_d;
			rsp_valid_q  <= rsp_valid_d;
			count_q      <= count_d;
			free_cnt_q   <= free_cnt_d;
			heap_top_q   <= heap_top_d;
			free_bytes_q <= free_bytes_d;
			used_q       <= used_d;
			if (cfg_we) begin
				unique case (ffba_pkg::cfg_reg_t'(cfg_index))
					ffba_pkg::CFG_HEAP_LIMIT:   limit_q <= cfg_data;
					ffba_pkg::CFG_HEADER_BYTES: hdr_q   <= cfg_data[ffba_pkg::HDR_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		rsize_q    <= rsize_d;
		ecount_q   <= ecount_d;
		baddr_q    <= baddr_d;
		size_q     <= size_d;
		find_q     <= find_d;
		idx_q      <= idx_d;
		pidx_s1    <= idx_q[IDX_W-1:0];
		move_q     <= move_d;
		old_idx_q  <= old_idx_d;
		old_size_q <= old_size_d;
		old_free_q <= old_free_d;
		res_q      <= res_d;
		ok_q       <= ok_d;
		msrc_q     <= msrc_d;
		mbytes_q   <= mbytes_d;
		end_q      <= end_d;
		base_q     <= base_d;
		rsp_q      <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(MAX_BLOCKS), "block count above table depth")
	`ASSERT_RST(a_free_le_total, free_cnt_q <= count_q, "free block count above block count")
	`ASSERT_RST(a_idle_no_read, state_q == ffba_pkg::S_IDLE |-> !pend_s1, "table read left pending")
	`ASSERT_RST(a_rsp_from_done, $rose(rsp_valid) |-> $past(state_q) == ffba_pkg::S_DONE, "result loaded outside done")

endmodule

`default_nettype wire

>>> sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ffba_pkg::*;

	localparam int TABLE_DEPTH = DEFAULT_MAX_BLOCKS;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE_CYCLES = 200;
	localparam int RANDOM_PER_PHASE = 450;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [ADDR_W-1:0] cfg_data;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	// allocator state as the testbench sees it
	logic [ADDR_W-1:0] block_start [TABLE_DEPTH];
	logic [ADDR_W-1:0] block_size [TABLE_DEPTH];
	bit block_free [TABLE_DEPTH];
	int unsigned block_total = 0;
	int unsigned free_block_count = 0;
	logic [ADDR_W-1:0] heap_top = '0;
	logic [ADDR_W-1:0] free_byte_sum = '0;
	logic [ADDR_W-1:0] used_byte_sum = '0;
	logic [ADDR_W-1:0] heap_limit = HEAP_LIMIT_RST;
	logic [HDR_W-1:0] header_bytes = HEADER_RST;

	rsp_t pending_responses [$];
	int error_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	first_fit_block_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	always @(posedge clk) begin : response_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_responses.size() == 0) begin
				report_mismatch("response with none pending", rsp_data.result_address, '0);
			end else begin
				want = pending_responses.pop_front();
				if (rsp_data.result_address !== want.result_address)
					report_mismatch("result_address", rsp_data.result_address, want.result_address);
				if (rsp_data.success !== want.success)
					report_mismatch("success", rsp_data.success, want.success);
				if (rsp_data.zero_fill_bytes !== want.zero_fill_bytes)
					report_mismatch("zero_fill_bytes", rsp_data.zero_fill_bytes,
						want.zero_fill_bytes);
				if (rsp_data.move_source !== want.move_source)
					report_mismatch("move_source", rsp_data.move_source, want.move_source);
				if (rsp_data.move_bytes !== want.move_bytes)
					report_mismatch("move_bytes", rsp_data.move_bytes, want.move_bytes);
				if (rsp_data.free_blocks !== want.free_blocks)
					report_mismatch("free_blocks", rsp_data.free_blocks, want.free_blocks);
				if (rsp_data.free_bytes !== want.free_bytes)
					report_mismatch("free_bytes", rsp_data.free_bytes, want.free_bytes);
				if (rsp_data.total_blocks !== want.total_blocks)
					report_mismatch("total_blocks", rsp_data.total_blocks, want.total_blocks);
				if (rsp_data.total_bytes !== want.total_bytes)
					report_mismatch("total_bytes", rsp_data.total_bytes, want.total_bytes);
				if (rsp_data.metadata_bytes !== want.metadata_bytes)
					report_mismatch("metadata_bytes", rsp_data.metadata_bytes,
						want.metadata_bytes);
			end
		end
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic bit try_allocate(input logic [63:0] size, output logic [ADDR_W-1:0] addr);
		logic [63:0] block_end;
		addr = '0;
		if (size == 0 || size > SIZE_CAP)
			return 1'b0;
		for (int i = 0; i < block_total; i++) begin
			if (block_free[i] && size <= block_size[i]) begin
				block_free[i] = 1'b0;
				free_block_count--;
				free_byte_sum -= block_size[i];
				addr = block_start[i];
				return 1'b1;
			end
		end
		if (block_total >= TABLE_DEPTH)
			return 1'b0;
		block_end = 64'(heap_top) + 64'(header_bytes) + size;
		if (block_end > 64'(heap_limit))
			return 1'b0;
		addr = heap_top + ADDR_W'(header_bytes);
		block_start[block_total] = addr;
		block_size[block_total] = size[ADDR_W-1:0];
		block_free[block_total] = 1'b0;
		block_total++;
		heap_top = block_end[ADDR_W-1:0];
		used_byte_sum += size[ADDR_W-1:0];
		return 1'b1;
	endfunction

	function automatic int find_block(input logic [ADDR_W-1:0] addr);
		for (int i = 0; i < block_total; i++)
			if (block_start[i] == addr)
				return i;
		return -1;
	endfunction

	function automatic void release_block(input int idx);
		if (!block_free[idx]) begin
			block_free[idx] = 1'b1;
			free_block_count++;
			free_byte_sum += block_size[idx];
		end
	endfunction

	function automatic rsp_t compute_heap_response(input req_t request);
		rsp_t outcome;
		logic [63:0] product;
		logic [ADDR_W-1:0] addr;
		bit ok;
		int idx;
		outcome = '0;
		addr = '0;
		ok = 1'b0;
		product = 64'(request.request_size) * 64'(request.element_count);
		case (opcode_t'(request.opcode))
			OP_ALLOC: begin
				ok = try_allocate(64'(request.request_size), addr);
			end
			OP_FREE: begin
				if (request.block_address == '0) begin
					ok = 1'b1;
				end else begin
					idx = find_block(request.block_address);
					if (idx >= 0) begin
						release_block(idx);
						ok = 1'b1;
					end
				end
			end
			OP_REALLOC: begin
				if (request.request_size == '0 || request.request_size > SIZE_CAP) begin
					ok = 1'b0;
				end else if (request.block_address == '0) begin
					ok = try_allocate(64'(request.request_size), addr);
				end else begin
					idx = find_block(request.block_address);
					if (idx >= 0) begin
						if (request.request_size <= block_size[idx]) begin
							addr = request.block_address;
							ok = 1'b1;
						end else if (try_allocate(64'(request.request_size), addr)) begin
							outcome.move_source = request.block_address;
							outcome.move_bytes = block_size[idx][SIZE_W-1:0];
							release_block(idx);
							ok = 1'b1;
						end
					end
				end
			end
			default: begin
				ok = try_allocate(product, addr);
				if (ok)
					outcome.zero_fill_bytes = product[SIZE_W-1:0];
			end
		endcase
		outcome.result_address = ok ? addr : '0;
		outcome.success = ok;
		outcome.free_blocks = CNT_FLD_W'(free_block_count);
		outcome.free_bytes = free_byte_sum;
		outcome.total_blocks = CNT_FLD_W'(block_total);
		outcome.total_bytes = used_byte_sum;
		outcome.metadata_bytes = MD_FLD_W'(header_bytes * block_total);
		return outcome;
	endfunction

	function automatic req_t pack_request(input opcode_t op, input logic [ADDR_W-1:0] size,
			input logic [ADDR_W-1:0] count, input logic [ADDR_W-1:0] addr);
		req_t request;
		request.opcode = op;
		request.request_size = size;
		request.element_count = count;
		request.block_address = addr;
		return request;
	endfunction

	function automatic logic [ADDR_W-1:0] random_size();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return $urandom_range(256, 1);
		if (pick < 90)
			return $urandom_range(65536, 257);
		if (pick < 97)
			return $urandom_range(SIZE_CAP, 65537);
		if (pick < 98)
			return '0;
		if (pick < 99)
			return ADDR_W'(SIZE_CAP) + $urandom_range(1);
		return $urandom();
	endfunction

	function automatic logic [ADDR_W-1:0] random_address();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		if (block_total == 0 || pick >= 92)
			return $urandom();
		if (pick >= 87)
			return block_start[$urandom_range(block_total - 1)] + 1;
		return block_start[$urandom_range(block_total - 1)];
	endfunction

	function automatic req_t random_request();
		req_t request;
		int unsigned pick;
		request.opcode = OP_ALLOC;
		request.request_size = random_size();
		request.element_count = $urandom();
		request.block_address = $urandom();
		pick = $urandom_range(99);
		if (pick < 34) begin
			request.opcode = OP_ALLOC;
		end else if (pick < 56) begin
			request.opcode = OP_FREE;
			request.block_address = random_address();
		end else if (pick < 74) begin
			request.opcode = OP_REALLOC;
			request.block_address = random_address();
		end else if (pick < 88) begin
			request.opcode = OP_CALLOC;
			request.request_size = $urandom_range(512, 1);
			request.element_count = $urandom_range(64, 1);
			if ($urandom_range(19) == 0)
				request.element_count = $urandom();
			if ($urandom_range(29) == 0)
				request.request_size = '0;
		end else begin
			request.opcode = 2'($urandom_range(3));
			request.request_size = $urandom();
		end
		return request;
	endfunction

	function automatic logic [ADDR_W-1:0] limit_above_top(input logic [ADDR_W-1:0] room);
		logic [ADDR_W:0] sum;
		sum = {1'b0, heap_top} + {1'b0, room};
		return sum[ADDR_W] ? '1 : sum[ADDR_W-1:0];
	endfunction

	task automatic send_request(input req_t request, output rsp_t predicted);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= request;
		do
			@(posedge clk);
		while (req_stall);
		predicted = compute_heap_response(request);
		pending_responses.push_back(predicted);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(input logic [ADDR_W-1:0] limit, input logic [HDR_W-1:0] header);
		drain_responses();
		cfg_we <= 1'b1;
		cfg_index <= CFG_HEAP_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_index <= CFG_HEADER_BYTES;
		cfg_data <= ADDR_W'(header);
		@(posedge clk);
		cfg_we <= 1'b0;
		heap_limit = limit;
		header_bytes = header;
	endtask

	task automatic test_header_zero();
		rsp_t predicted;
		configure(HEAP_LIMIT_RST, '0);
		send_request(pack_request(OP_FREE, '0, '0, 32'd5), predicted);
		send_request(pack_request(OP_REALLOC, 32'd4, '0, 32'd5), predicted);
		send_request(pack_request(OP_ALLOC, 32'd8, '0, '0), predicted);
		send_request(pack_request(OP_FREE, '0, '0, '0), predicted);
	endtask

	task automatic test_bad_sizes();
		rsp_t predicted;
		logic [ADDR_W-1:0] big_block;
		configure('1, 7'd64);
		send_request(pack_request(OP_ALLOC, '0, '0, '0), predicted);
		send_request(pack_request(OP_ALLOC, ADDR_W'(SIZE_CAP) + 1, '0, '0), predicted);
		send_request(pack_request(OP_ALLOC, '1, '1, '1), predicted);
		send_request(pack_request(OP_ALLOC, ADDR_W'(SIZE_CAP), '0, '0), predicted);
		big_block = predicted.result_address;
		send_request(pack_request(OP_CALLOC, '0, 32'd5, '0), predicted);
		send_request(pack_request(OP_CALLOC, 32'd65536, 32'd65536, '0), predicted);
		send_request(pack_request(OP_CALLOC, '1, '1, '0), predicted);
		send_request(pack_request(OP_CALLOC, 32'd10000, 32'd10000, '0), predicted);
		send_request(pack_request(OP_REALLOC, '0, '0, big_block), predicted);
		send_request(pack_request(OP_REALLOC, ADDR_W'(SIZE_CAP) + 1, '0, big_block), predicted);
	endtask

	task automatic test_heap_limit();
		rsp_t predicted;
		// room for exactly one 100 byte payload behind a 64 byte header
		configure(limit_above_top(32'd164), 7'd64);
		send_request(pack_request(OP_ALLOC, 32'd101, '0, '0), predicted);
		send_request(pack_request(OP_ALLOC, 32'd100, '0, '0), predicted);
		send_request(pack_request(OP_ALLOC, 32'd1, '0, '0), predicted);
		configure('0, 7'd127);
		send_request(pack_request(OP_ALLOC, 32'd1, '0, '0), predicted);
	endtask

	task automatic test_free_and_reallocate();
		rsp_t predicted;
		logic [ADDR_W-1:0] wide_block;
		logic [ADDR_W-1:0] narrow_block;
		configure('1, 7'd32);
		send_request(pack_request(OP_ALLOC, 32'd200, '0, '0), predicted);
		wide_block = predicted.result_address;
		send_request(pack_request(OP_ALLOC, 32'd50, '0, '0), predicted);
		narrow_block = predicted.result_address;
		send_request(pack_request(OP_CALLOC, 32'd10, 32'd10, '0), predicted);
		send_request(pack_request(OP_FREE, '0, '0, 32'd3), predicted);
		send_request(pack_request(OP_FREE, '0, '0, wide_block), predicted);
		send_request(pack_request(OP_FREE, '0, '0, wide_block), predicted);
		send_request(pack_request(OP_ALLOC, 32'd150, '0, '0), predicted);
		send_request(pack_request(OP_FREE, '0, '0, wide_block), predicted);
		send_request(pack_request(OP_REALLOC, 32'd10, '0, wide_block), predicted);
		send_request(pack_request(OP_REALLOC, 32'd40, '0, narrow_block), predicted);
		send_request(pack_request(OP_REALLOC, 32'd60, '0, narrow_block), predicted);
		narrow_block = predicted.result_address;
		send_request(pack_request(OP_REALLOC, 32'd16, '0, '0), predicted);
		send_request(pack_request(OP_REALLOC, 32'd8, '0, 32'hDEAD_BEEF), predicted);
		// growth blocked, so the moving reallocate fails and the old block stays
		configure('0, 7'd32);
		send_request(pack_request(OP_REALLOC, 32'd100000, '0, narrow_block), predicted);
		send_request(pack_request(OP_FREE, '0, '0, narrow_block), predicted);
	endtask

	task automatic random_phase(input int sender_pct, input int receiver_pct,
			input logic [ADDR_W-1:0] limit, input logic [HDR_W-1:0] header);
		rsp_t predicted;
		configure(limit, header);
		send_idle_pct = sender_pct;
		stall_pct = receiver_pct;
		repeat (RANDOM_PER_PHASE)
			send_request(random_request(), predicted);
		drain_responses();
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_random_traffic();
		random_phase(0, 0, limit_above_top(32'h0010_0000), 7'd16);
		random_phase(45, 0, limit_above_top(32'h0400_0000), 7'd64);
		random_phase(0, 45, '1, 7'd127);
		random_phase(15, 15, '0, 7'd0);
	endtask

	task automatic test_table_full();
		rsp_t predicted;
		configure('1, 7'd8);
		send_idle_pct = 15;
		stall_pct = 15;
		// use up every free block, then grow until the table has no room
		do
			send_request(pack_request(OP_ALLOC, 32'd1, '0, '0), predicted);
		while (predicted.success && (free_block_count != 0 || block_total < TABLE_DEPTH));
		send_request(pack_request(OP_ALLOC, 32'd1, '0, '0), predicted);
		send_request(pack_request(OP_CALLOC, 32'd4, 32'd4, '0), predicted);
		send_request(pack_request(OP_REALLOC, 32'd2, '0, block_start[TABLE_DEPTH - 1]), predicted);
		req_valid <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_HEAP_LIMIT;
		cfg_data <= '0;
		req_valid <= 1'b0;
		req_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_zero();
		test_bad_sizes();
		test_heap_limit();
		test_free_and_reallocate();
		test_random_traffic();
		test_table_full();
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_responses.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
